// ----- rtl/feedback_echo_delay_macros.svh -----
// Assertion macros for the feedback echo delay checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef FEEDBACK_ECHO_DELAY_MACROS_SVH
`define FEEDBACK_ECHO_DELAY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FED_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("echo checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define FED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("echo checker: next-cycle property failed");

`endif

// ----- rtl/fed_pkg.sv -----
// Shared types and constants for the feedback echo delay block.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package fed_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int DELAY_W         = 15;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int ECHO_SHIFT      = 15;
    localparam int DELAY_DEPTH_DEF = 32768;
    localparam int DELAY_RESET     = 24000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t GAIN_RESET = 16'sh4000;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_DRY_GAIN = 2'd1,
        REG_WET_GAIN = 2'd2
    } fed_reg_t;

    typedef struct packed {
        sample_t dry_gain;
        sample_t wet_gain;
    } fed_gain_t;

endpackage

// ----- rtl/fed_in_if.sv -----
// Input sample channel: valid/ready handshake carrying one dry sample.
// Depends on fed_pkg.
`timescale 1ns / 1ps

interface fed_in_if
    import fed_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t dry_in;

    modport source (output valid, output dry_in, input ready);
    modport sink   (input valid, input dry_in, output ready);
endinterface

// ----- rtl/fed_out_if.sv -----
// Output sample channel: valid/ready handshake carrying one echo sample.
// Depends on fed_pkg.
`timescale 1ns / 1ps

interface fed_out_if
    import fed_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t echo_out;

    modport source (output valid, output echo_out, input ready);
    modport sink   (input valid, input echo_out, output ready);
endinterface

// ----- rtl/fed_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and data.
// Depends on fed_pkg.
`timescale 1ns / 1ps

interface fed_cfg_if
    import fed_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/feedback_echo_delay.sv -----
// Channel  | Dir | Payload                      | Beat taken when
// dry      | in  | dry_in  (s16)                | dry.valid && dry.ready
// echo     | out | echo_out (s16)               | echo.valid && echo.ready
// cfg      | in  | reg_index (2b), wdata (16b)  | cfg.valid && cfg.ready
//
// One sample per cycle sustained while echo.ready stays high; the delay memory read
// is registered at the input beat (stage 1), and the multiply-add result goes into
// the output register once stage 1 advances; that register drives echo.valid.
// A delay of one is served by forwarding the previous result.
// Reset (rst_n, async) clears pointer, control and config; the delay line
// needs no clearing pass: entries not yet written since reset read as zero,
// tracked by the write pointer and a wrap flag. cfg.ready is always high.
// A stalled output holds its beat; dry.ready drops only while both stages are
// full and echo.ready is low.
`timescale 1ns / 1ps

module feedback_echo_delay
    import fed_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fed_in_if.sink    dry,
    fed_out_if.source echo,
    fed_cfg_if.sink   cfg
);

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

    logic [AW-1:0] delay_dist;
    fed_gain_t     gains;

    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          s1_fwd_reg, s1_zero_reg;
    logic [AW-1:0] s1_wp_reg;
    sample_t       s1_dry_reg;
    sample_t       last_res_reg;
    sample_t       out_res_reg;

    logic          accept;
    logic          s1_adv;
    logic          wp_last;
    logic [AW:0]   diff;
    logic [AW:0]   diff_wrap;
    logic [AW-1:0] rd_addr;
    logic          fwd;
    logic          unwritten;
    sample_t       mem_q;
    sample_t       wet;
    sample_t       result;

    fed_cfg_regs #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .delay_dist (delay_dist),
        .gains      (gains)
    );

    // Pipeline handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || echo.ready);
    assign dry.ready = !s1_valid_reg || s1_adv;
    assign accept    = dry.valid && dry.ready;

    // Read address: write pointer minus distance, modulo depth
    assign diff      = {1'b0, wp_reg} - {1'b0, delay_dist};
    assign diff_wrap = diff + (AW+1)'(DELAY_DEPTH);
    assign rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

    // The item leaving stage 1 writes the memory on this same edge
    assign fwd       = s1_adv && (rd_addr == s1_wp_reg);
    assign unwritten = !wrapped_reg && (rd_addr >= wp_reg);

    assign wp_last   = (wp_reg == AW'(DELAY_DEPTH - 1));

    always_comb
    begin
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            wp_next = wp_last ? '0 : wp_reg + AW'(1);
            if (wp_last)
            begin
                wrapped_next = 1'b1;
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (echo.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dry_reg  <= dry.dry_in;
            s1_wp_reg   <= wp_reg;
            s1_fwd_reg  <= fwd;
            s1_zero_reg <= unwritten;
        end
        if (s1_adv)
        begin
            last_res_reg <= result;
            out_res_reg  <= result;
        end
    end

    fed_delay_mem #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_mem (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_wp_reg),
        .wdata (result),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            wet = last_res_reg;
        end
        else if (s1_zero_reg)
        begin
            wet = '0;
        end
        else
        begin
            wet = mem_q;
        end
    end

    fed_mac u_mac (
        .dry    (s1_dry_reg),
        .wet    (wet),
        .gains  (gains),
        .result (result)
    );

    assign echo.valid    = out_valid_reg;
    assign echo.echo_out = out_res_reg;

endmodule

// ----- rtl/fed_cfg_regs.sv -----
// Configuration registers: echo distance and the two Q1.15 gains.
// Depends on fed_pkg and fed_cfg_if.
`timescale 1ns / 1ps

module fed_cfg_regs
    import fed_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int AW          = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    fed_cfg_if.sink          cfg,
    output logic [AW-1:0]    delay_dist,
    output fed_gain_t        gains
);

    // Distance is kept modulo the depth: a delay equal to the depth reads
    // the entry about to be overwritten.
    localparam int DIST_RESET = DELAY_RESET % DELAY_DEPTH;

    logic [AW-1:0]      delay_dist_reg, delay_dist_next;
    fed_gain_t          gains_reg, gains_next;
    logic [DELAY_W-1:0] delay_wr;
    logic [31:0]        delay_wide;
    logic               delay_ok;
    fed_reg_t           sel;

    assign cfg.ready  = 1'b1;
    assign sel        = fed_reg_t'(cfg.reg_index);
    assign delay_wr   = cfg.wdata[DELAY_W-1:0];
    assign delay_wide = 32'(delay_wr);
    assign delay_ok   = (delay_wide != 32'd0) && (delay_wide <= 32'(DELAY_DEPTH));

    always_comb
    begin
        delay_dist_next = delay_dist_reg;
        gains_next      = gains_reg;
        if (cfg.valid)
        begin
            unique case (sel)
                REG_DELAY:
                begin
                    // drop out-of-range delay writes
                    if (delay_ok)
                    begin
                        delay_dist_next = (delay_wide == 32'(DELAY_DEPTH)) ? '0
                                                                           : delay_wide[AW-1:0];
                    end
                end
                REG_DRY_GAIN: gains_next.dry_gain = sample_t'(cfg.wdata);
                REG_WET_GAIN: gains_next.wet_gain = sample_t'(cfg.wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_dist_reg     <= AW'(DIST_RESET);
            gains_reg.dry_gain <= GAIN_RESET;
            gains_reg.wet_gain <= GAIN_RESET;
        end
        else
        begin
            delay_dist_reg <= delay_dist_next;
            gains_reg      <= gains_next;
        end
    end

    assign delay_dist = delay_dist_reg;
    assign gains      = gains_reg;

endmodule

// ----- rtl/fed_delay_mem.sv -----
// Delay line storage: one write port and one registered read port.
// Depends on fed_pkg.
`timescale 1ns / 1ps

module fed_delay_mem
    import fed_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int AW          = 15
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  sample_t       wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output sample_t       rdata
);

    sample_t mem [DELAY_DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fed_mac.sv -----
// Multiply-accumulate of dry and delayed samples with Q1.15 gains.
// Depends on fed_pkg. Sum wraps in 32 bits, result is bits [30:15].
`timescale 1ns / 1ps

module fed_mac
    import fed_pkg::*;
(
    input  sample_t   dry,
    input  sample_t   wet,
    input  fed_gain_t gains,
    output sample_t   result
);

    logic signed [2*SAMPLE_W-1:0] dry_prod;
    logic signed [2*SAMPLE_W-1:0] wet_prod;
    logic        [2*SAMPLE_W-1:0] acc;

    assign dry_prod = dry * gains.dry_gain;
    assign wet_prod = wet * gains.wet_gain;
    assign acc      = dry_prod + wet_prod;
    assign result   = sample_t'(acc[ECHO_SHIFT +: SAMPLE_W]);

endmodule

// ----- rtl/fed_checker.sv -----
// Port-level checker for feedback_echo_delay, attached by bind.
// Depends on fed_pkg and feedback_echo_delay_macros.svh.
`timescale 1ns / 1ps
`include "feedback_echo_delay_macros.svh"

module fed_checker
    import fed_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t echo_out
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] pending_reg, pending_next;

    assign in_beat      = in_valid && in_ready;
    assign out_beat     = out_valid && out_ready;
    assign pending_next = pending_reg + 2'(in_beat) - 2'(out_beat);

    // count samples taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `FED_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)
    `FED_ASSERT_NEXT(a_out_data_holds, out_valid && !out_ready, $stable(echo_out))
    `FED_ASSERT_SAME(a_no_invented_result, out_beat, pending_reg != 2'd0)
    `FED_ASSERT_SAME(a_two_in_flight_max, 1'b1, pending_reg != 2'd3)

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dry.valid),
    .in_ready  (dry.ready),
    .out_valid (echo.valid),
    .out_ready (echo.ready),
    .echo_out  (echo.echo_out)
);

// ----- tb/testbench.sv -----
// Self-checking bench for feedback_echo_delay: in-bench echo predictor, random idling.
// Depends on fed_pkg, the fed_*_if channel interfaces and the feedback_echo_delay RTL.
`timescale 1ns / 1ps

module testbench;
    import fed_pkg::*;

    localparam int ECHO_DEPTH  = DELAY_DEPTH_DEF;
    localparam int QUIET_LIMIT = 1000;
    localparam int REPORT_CAP  = 40;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 100;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    fed_in_if  dry_ch ();
    fed_out_if echo_ch ();
    fed_cfg_if cfg_ch ();

    feedback_echo_delay dut (
        .clk   (clk),
        .rst_n (rst_n),
        .dry   (dry_ch),
        .echo  (echo_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: delay line, pointer and register copies
    sample_t            echo_mem [ECHO_DEPTH];
    logic [DELAY_W-1:0] wr_ptr;
    logic [DELAY_W-1:0] echo_delay;
    sample_t            gain_dry;
    sample_t            gain_wet;
    sample_t            pending_echo [$];

    bit idle_en;
    int quiet_cycles = 0;
    int n_samples    = 0;
    int n_echoes     = 0;
    int n_writes     = 0;
    int n_errors     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Feed one dry sample through the delay line, return the echo it yields
    function automatic sample_t echo_advance(sample_t x);
        logic [DELAY_W-1:0] rd;
        logic signed [31:0] acc;
        rd  = wr_ptr - echo_delay;
        acc = 32'(x) * 32'(gain_dry) + 32'(echo_mem[rd]) * 32'(gain_wet);
        echo_mem[wr_ptr] = acc[ECHO_SHIFT +: SAMPLE_W];
        wr_ptr = wr_ptr + 1'b1;
        return acc[ECHO_SHIFT +: SAMPLE_W];
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return -16'sh8000;
            2:       return '0;
            3:       return -16'sh0001;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_gain();
        case ($urandom_range(5))
            0:       return -16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic push_sample(sample_t x);
        if (idle_en && $urandom_range(99) < 4)
        begin
            dry_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        dry_ch.valid  <= 1'b1;
        dry_ch.dry_in <= x;
        @(posedge clk);
        while (!dry_ch.ready) @(posedge clk);
        pending_echo.push_back(echo_advance(x));
        n_samples++;
    endtask

    // Hold the input and wait for every outstanding echo
    task automatic settle();
        dry_ch.valid <= 1'b0;
        while (pending_echo.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_DELAY:    if (data[DELAY_W-1:0] != '0) echo_delay = data[DELAY_W-1:0];
            REG_DRY_GAIN: gain_dry = data;
            REG_WET_GAIN: gain_wet = data;
            default:      ;
        endcase
        n_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reset delay is far away, so the delay line reads as zero
    task automatic check_reset_state();
        push_sample(16'sh0000);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(-16'sh0001);
        push_sample(16'sh0001);
        push_sample(16'sh5555);
    endtask

    task automatic check_delay_limits();
        settle();
        write_reg(REG_DELAY, 16'h0000);
        write_reg(REG_DELAY, 16'h8000);
        write_reg(REG_UNUSED, 16'h0001);
        push_sample(16'sh1234);
        push_sample(-16'sh4321);
        settle();
        write_reg(REG_DELAY, 16'h0001);
        // back to back: each beat needs the echo of the one just before
        idle_en = 1'b0;
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(16'sh2000);
        push_sample(-16'sh0001);
        settle();
        idle_en = 1'b1;
    endtask

    // Gains at the rails; the sum of two full-scale products wraps the accumulator
    task automatic check_gain_extremes();
        settle();
        write_reg(REG_DRY_GAIN, 16'h8000);
        write_reg(REG_WET_GAIN, 16'h8000);
        repeat (4) push_sample(-16'sh8000);
        settle();
        write_reg(REG_DRY_GAIN, 16'h7fff);
        write_reg(REG_WET_GAIN, 16'h7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(16'sh7fff);
        settle();
        write_reg(REG_DELAY, 16'h0002);
        write_reg(REG_DRY_GAIN, 16'h8000);
        push_sample(-16'sh8000);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(-16'sh8000);
    endtask

    // Longest delay: every read lands on an entry not yet written since reset
    task automatic check_long_delay();
        settle();
        write_reg(REG_DELAY, 16'h7fff);
        write_reg(REG_DRY_GAIN, 16'h3000);
        write_reg(REG_WET_GAIN, 16'h5000);
        repeat (120) push_sample(pick_sample());
        settle();
        write_reg(REG_DELAY, 16'(DELAY_RESET));
        repeat (40) push_sample(pick_sample());
    endtask

    task automatic check_random_traffic();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase % 5 == 4) write_reg(REG_DELAY, 16'h0000);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: write_reg(REG_DELAY, 16'($urandom_range(1, 16)));
                6, 7:             write_reg(REG_DELAY, 16'($urandom_range(17, 4000)));
                8:                write_reg(REG_DELAY, 16'h7fff);
                default:          write_reg(REG_DELAY, 16'($urandom_range(1, 2)));
            endcase
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_DRY_GAIN, pick_gain());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_WET_GAIN, pick_gain());
            if ($urandom_range(7) == 0) write_reg(REG_UNUSED, 16'($urandom));
            // one long stretch at full rate on both sides
            idle_en = (phase != 6);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 3 && i == PHASE_ITEMS / 2) settle();
                push_sample(pick_sample());
            end
        end
        settle();
        idle_en = 1'b1;
    endtask

    // Echo sink: random stalls, compare each beat with the oldest prediction
    initial
    begin : echo_sink
        int      stall_left;
        sample_t want;
        stall_left    = 0;
        echo_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && echo_ch.valid && echo_ch.ready)
            begin
                n_echoes++;
                if (pending_echo.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= REPORT_CAP)
                        $display("%0t: echo_out %0d with no sample pending", $time,
                                 echo_ch.echo_out);
                end
                else
                begin
                    want = pending_echo.pop_front();
                    if (echo_ch.echo_out !== want)
                    begin
                        n_errors++;
                        if (n_errors <= REPORT_CAP)
                            $display("%0t: echo_out expected %0d, got %0d", $time, want,
                                     echo_ch.echo_out);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                echo_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(99) < 4)
            begin
                stall_left = $urandom_range(3);
                echo_ch.ready <= 1'b0;
            end
            else
            begin
                echo_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((dry_ch.valid && dry_ch.ready) || (echo_ch.valid && echo_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog: no beat for %0d cycles, %0d echoes outstanding",
                     $time, quiet_cycles, pending_echo.size());
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        idle_en          = 1'b1;
        dry_ch.valid     = 1'b0;
        dry_ch.dry_in    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wdata     = '0;
        foreach (echo_mem[i]) echo_mem[i] = '0;
        wr_ptr     = '0;
        echo_delay = DELAY_W'(DELAY_RESET);
        gain_dry   = GAIN_RESET;
        gain_wet   = GAIN_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_state();
        check_delay_limits();
        check_gain_extremes();
        check_long_delay();
        check_random_traffic();

        settle();
        repeat (8) @(posedge clk);
        n_errors += pending_echo.size();

        $display("run: %0d samples in, %0d echoes out, %0d register writes, %0d mismatches",
                 n_samples, n_echoes, n_writes, n_errors);
        $display("run: delays 1 to 32767 incl. rejected writes, rail gains, long-delay reads");
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
